// ===== sv/vt4_pkg.sv =====
// vt4_pkg: shared types and constants of the 4x4 vertex transform pipeline.
// No dependencies.
`default_nettype none

package vt4_pkg;

    localparam int DIM      = 4;
    localparam int NUM_REGS = 8;
    localparam int IDX_W    = 4;
    localparam int ELEM_W   = 32;
    localparam int PROD_W   = 2 * ELEM_W;
    localparam int PAIR_W   = PROD_W + 1;
    localparam int SUM_W    = PROD_W + 2;

    typedef logic [DIM-1:0][DIM-1:0][ELEM_W-1:0] mat_t;
    typedef logic [DIM-1:0][ELEM_W-1:0]          vec_t;
    typedef logic [DIM-1:0][DIM-1:0][PROD_W-1:0] prod_t;
    typedef logic [DIM-1:0][1:0][PAIR_W-1:0]     pair_t;
    typedef logic [DIM-1:0][SUM_W-1:0]           sum_t;

    typedef struct packed {
        logic valid;
        logic en;
    } stage_ctl_t;

    function automatic logic [PROD_W-1:0] mul_s(input logic [ELEM_W-1:0] a,
                                                input logic [ELEM_W-1:0] b);
        logic signed [PROD_W-1:0] sa;
        logic signed [PROD_W-1:0] sb;
        sa = {{(PROD_W-ELEM_W){a[ELEM_W-1]}}, a};
        sb = {{(PROD_W-ELEM_W){b[ELEM_W-1]}}, b};
        return PROD_W'(sa * sb);
    endfunction

endpackage

`default_nettype wire

// ===== sv/vt4_mul.sv =====
// vt4_mul: first stage, sixteen signed 32x32 products, registered.
// Depends on vt4_pkg.
`default_nettype none

module vt4_mul
    import vt4_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire stage_ctl_t ctl,
    input  wire mat_t       mat,
    input  wire vec_t       vec,
    output logic            valid_reg,
    output prod_t           prod_reg
);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            for (int r = 0; r < DIM; r++)
            begin
                for (int c = 0; c < DIM; c++)
                begin
                    prod_reg[r][c] <= mul_s(mat[r][c], vec[c]);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/vt4_acc.sv =====
// vt4_acc: two adder stages, pairwise product sums then row total plus rounding.
// Depends on vt4_pkg.
`default_nettype none

module vt4_acc
    import vt4_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire stage_ctl_t ctl_pair,
    input  wire stage_ctl_t ctl_sum,
    input  wire prod_t      prod,
    output logic            pair_valid_reg,
    output logic            sum_valid_reg,
    output sum_t            sum_reg
);

    localparam logic [SUM_W-1:0] RND =
        (FRAC_BITS > 0) ? (SUM_W'(1) << (FRAC_BITS - 1)) : '0;

    pair_t pair_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl_pair.en)
            begin
                pair_valid_reg <= ctl_pair.valid;
            end
            if (ctl_sum.en)
            begin
                sum_valid_reg <= ctl_sum.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_pair.en)
        begin
            for (int r = 0; r < DIM; r++)
            begin
                for (int h = 0; h < 2; h++)
                begin
                    pair_reg[r][h] <= {prod[r][2*h][PROD_W-1], prod[r][2*h]}
                                    + {prod[r][2*h+1][PROD_W-1], prod[r][2*h+1]};
                end
            end
        end
        if (ctl_sum.en)
        begin
            for (int r = 0; r < DIM; r++)
            begin
                sum_reg[r] <= {pair_reg[r][0][PAIR_W-1], pair_reg[r][0]}
                            + {pair_reg[r][1][PAIR_W-1], pair_reg[r][1]}
                            + RND;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/vt4_sat.sv =====
// vt4_sat: last stage, fraction shift and 32-bit saturation into the output register.
// Depends on vt4_pkg.
`default_nettype none

module vt4_sat
    import vt4_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire stage_ctl_t ctl,
    input  wire sum_t       sum,
    output logic            valid_reg,
    output vec_t            res_reg,
    output logic            sat_reg
);

    localparam logic [ELEM_W-1:0] MAX_VAL = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] MIN_VAL = {1'b1, {(ELEM_W-1){1'b0}}};

    vec_t             res_next;
    logic [DIM-1:0]   clip;
    logic [SUM_W-1:0] shifted [DIM];

    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            shifted[r] = SUM_W'($signed(sum[r]) >>> FRAC_BITS);
            clip[r]    = !((&shifted[r][SUM_W-1:ELEM_W-1])
                        || !(|shifted[r][SUM_W-1:ELEM_W-1]));
            if (!clip[r])
            begin
                res_next[r] = shifted[r][ELEM_W-1:0];
            end
            else if (shifted[r][SUM_W-1])
            begin
                res_next[r] = MIN_VAL;
            end
            else
            begin
                res_next[r] = MAX_VAL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            res_reg <= res_next;
            sat_reg <= |clip;
        end
    end

endmodule

`default_nettype wire

// ===== sv/vertex_transform_4x4.sv =====
// vertex_transform_4x4: out = M * vec, Q16.16, rounded half up and saturated.
// Stages: multiply, pair add, row add with rounding, shift/saturate.
// Throughput one vector per cycle while res_ready is high; a stalled result holds and bubbles collapse.
// Reset (rst_n low, async) clears all stage valid bits and loads the identity matrix.
// Depends on vt4_pkg, vt4_mul, vt4_acc, vt4_sat.
`default_nettype none

module vertex_transform_4x4
    import vt4_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [IDX_W-1:0]         cfg_index,
    input  wire logic [PROD_W-1:0]        cfg_data,
    input  wire logic                     vec_valid,
    output logic                          vec_ready,
    input  wire logic signed [ELEM_W-1:0] vec_x,
    input  wire logic signed [ELEM_W-1:0] vec_y,
    input  wire logic signed [ELEM_W-1:0] vec_z,
    input  wire logic signed [ELEM_W-1:0] vec_w,
    output logic                          res_valid,
    input  wire logic                     res_ready,
    output logic signed [ELEM_W-1:0]      out_x,
    output logic signed [ELEM_W-1:0]      out_y,
    output logic signed [ELEM_W-1:0]      out_z,
    output logic signed [ELEM_W-1:0]      out_w,
    output logic                          saturated
);

    localparam logic [ELEM_W-1:0] ONE = ELEM_W'(1) << FRAC_BITS;

    logic [PROD_W-1:0] cfg_reg [NUM_REGS];
    mat_t              mat;
    vec_t              vec;
    vec_t              res;
    prod_t             prod;
    sum_t              sum;
    logic              mul_valid;
    logic              pair_valid;
    logic              sum_valid;
    logic              en_mul;
    logic              en_pair;
    logic              en_sum;
    logic              en_out;
    stage_ctl_t        ctl_mul;
    stage_ctl_t        ctl_pair;
    stage_ctl_t        ctl_sum;
    stage_ctl_t        ctl_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= '0;
                if (i / 2 == 2 * (i % 2))
                begin
                    cfg_reg[i][ELEM_W-1:0] <= ONE;
                end
                if (i / 2 == 2 * (i % 2) + 1)
                begin
                    cfg_reg[i][PROD_W-1:ELEM_W] <= ONE;
                end
            end
        end
        else if (cfg_valid && cfg_index < IDX_W'(NUM_REGS))
        begin
            cfg_reg[cfg_index[$clog2(NUM_REGS)-1:0]] <= cfg_data;
        end
    end

    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                mat[r][c] = cfg_reg[2*r + c/2][ELEM_W*(c%2) +: ELEM_W];
            end
        end
    end

    assign vec = {vec_w, vec_z, vec_y, vec_x};

    // stall chain: a stage moves when it is empty or the next one moves
    assign en_out    = !res_valid || res_ready;
    assign en_sum    = !sum_valid || en_out;
    assign en_pair   = !pair_valid || en_sum;
    assign en_mul    = !mul_valid || en_pair;
    assign vec_ready = en_mul;

    assign ctl_mul  = {vec_valid, en_mul};
    assign ctl_pair = {mul_valid, en_pair};
    assign ctl_sum  = {pair_valid, en_sum};
    assign ctl_out  = {sum_valid, en_out};

    vt4_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_mul),
        .mat       (mat),
        .vec       (vec),
        .valid_reg (mul_valid),
        .prod_reg  (prod)
    );

    vt4_acc #(
        .FRAC_BITS (FRAC_BITS)
    ) u_acc (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl_pair       (ctl_pair),
        .ctl_sum        (ctl_sum),
        .prod           (prod),
        .pair_valid_reg (pair_valid),
        .sum_valid_reg  (sum_valid),
        .sum_reg        (sum)
    );

    vt4_sat #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_out),
        .sum       (sum),
        .valid_reg (res_valid),
        .res_reg   (res),
        .sat_reg   (saturated)
    );

    assign out_x = res[0];
    assign out_y = res[1];
    assign out_z = res[2];
    assign out_w = res[3];

endmodule

`default_nettype wire
